>>> design/rsld_pkg.sv
// Shared widths and result type for the request stride lock detector.
package rsld_pkg;

   localparam int INDEX_W  = 31;
   localparam int STRIDE_W = 32;

   typedef logic [INDEX_W-1:0]         index_type;
   typedef logic signed [STRIDE_W-1:0] stride_type;

   typedef struct packed {
      logic       is_locked_out;
      stride_type locked_stride_out;
      stride_type prefetch_step;
   } result_type;

endpackage

>>> design/rsld_req_if.sv
// Request channel: one requested frame index per transaction.
interface rsld_req_if;
   logic                 valid;
   logic                 ready;
   rsld_pkg::index_type  frame_index;

   modport source (output valid, output frame_index, input ready);
   modport sink   (input valid, input frame_index, output ready);
endinterface

>>> design/rsld_rsp_if.sv
// Result channel: lock flag, locked stride and prefetch step per transaction.
interface rsld_rsp_if;
   logic                 valid;
   logic                 ready;
   logic                 is_locked_out;
   rsld_pkg::stride_type locked_stride_out;
   rsld_pkg::stride_type prefetch_step;

   modport source (output valid, output is_locked_out, output locked_stride_out,
                   output prefetch_step, input ready);
   modport sink   (input valid, input is_locked_out, input locked_stride_out,
                   input prefetch_step, output ready);
endinterface

>>> design/rsld_tracker.sv
// Stride tracker: holds detector state and computes the result of one request.
module rsld_tracker #(
   parameter int LOCK_LENGTH = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  rsld_pkg::index_type  frame_index,
   output rsld_pkg::result_type result
);

   localparam int CntW = $clog2(LOCK_LENGTH + 1);
   localparam logic [CntW-1:0] LockLen = CntW'(LOCK_LENGTH);

   rsld_pkg::index_type  last_index_ff, last_index_in;
   rsld_pkg::stride_type locked_stride_ff, locked_stride_in;
   rsld_pkg::stride_type candidate_stride_ff, candidate_stride_in;
   logic [CntW-1:0]      hit_count_ff, hit_count_in;
   logic [CntW-1:0]      miss_count_ff, miss_count_in;
   logic                 lock_flag_ff, lock_flag_in;

   rsld_pkg::stride_type diff;
   rsld_pkg::stride_type stride;
   logic                 eq_lock;
   logic                 eq_cand;
   logic [CntW-1:0]      hit_sat;
   logic [CntW-1:0]      miss_sat;

   always_comb begin
      diff     = rsld_pkg::stride_type'({1'b0, frame_index})
               - rsld_pkg::stride_type'({1'b0, last_index_ff});
      stride   = (diff == '0) ? rsld_pkg::stride_type'(1) : diff;
      eq_lock  = (locked_stride_ff == stride);
      eq_cand  = (candidate_stride_ff == stride);
      hit_sat  = (hit_count_ff >= LockLen) ? LockLen : hit_count_ff + CntW'(1);
      miss_sat = (miss_count_ff >= LockLen) ? LockLen : miss_count_ff + CntW'(1);

      last_index_in       = frame_index;
      locked_stride_in    = locked_stride_ff;
      candidate_stride_in = candidate_stride_ff;
      lock_flag_in        = lock_flag_ff;
      hit_count_in        = hit_count_ff;
      miss_count_in       = miss_count_ff;

      if (lock_flag_ff) begin
         if (eq_lock) begin
            hit_count_in  = '0;
            miss_count_in = '0;
         end else if (eq_cand) begin
            hit_count_in  = hit_sat;
            miss_count_in = miss_sat;
         end else begin
            hit_count_in  = '0;
            miss_count_in = miss_sat;
         end
         candidate_stride_in = stride;
         // relock onto the new stride, or drop the lock on repeated misses
         if (miss_count_in >= LockLen && hit_count_in >= LockLen) begin
            locked_stride_in = stride;
            hit_count_in     = '0;
            miss_count_in    = '0;
         end else if (miss_count_in >= LockLen) begin
            lock_flag_in = 1'b0;
         end
      end else begin
         if (eq_cand) begin
            hit_count_in  = hit_sat;
            miss_count_in = '0;
         end else begin
            hit_count_in  = '0;
            miss_count_in = miss_sat;
         end
         if (hit_count_in >= LockLen) begin
            locked_stride_in = stride;
            miss_count_in    = '0;
            lock_flag_in     = 1'b1;
         end
      end

      result.is_locked_out     = lock_flag_in;
      result.locked_stride_out = locked_stride_in;
      result.prefetch_step     = lock_flag_in ? locked_stride_in
                                              : rsld_pkg::stride_type'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_index_ff       <= '0;
         locked_stride_ff    <= rsld_pkg::stride_type'(1);
         candidate_stride_ff <= rsld_pkg::stride_type'(1);
         hit_count_ff        <= '0;
         miss_count_ff       <= '0;
         lock_flag_ff        <= 1'b0;
      end else if (step) begin
         last_index_ff       <= last_index_in;
         locked_stride_ff    <= locked_stride_in;
         candidate_stride_ff <= candidate_stride_in;
         hit_count_ff        <= hit_count_in;
         miss_count_ff       <= miss_count_in;
         lock_flag_ff        <= lock_flag_in;
      end
   end

   a_hit_bounded: assert property (@(posedge clock) disable iff (reset)
      hit_count_ff <= LockLen)
      else $error("hit counter above lock length");

   a_miss_bounded: assert property (@(posedge clock) disable iff (reset)
      miss_count_ff <= LockLen)
      else $error("miss counter above lock length");

   a_locked_nonzero: assert property (@(posedge clock) disable iff (reset)
      locked_stride_ff != '0)
      else $error("locked stride is zero");

endmodule

>>> design/request_stride_lock_detector_core.sv
// Request stride lock detector top level: input register, tracker, result register.
// Accepts one frame index per cycle and returns one result per request. The
// request sits in an input register; the stride subtract, the compares and the
// counter updates against the held detector state are combinational, and their
// output is captured in the result register. Throughput is one request per
// cycle, limited only by back pressure from the result channel. LOCK_LENGTH
// (1 to 7) sets how many stride repeats lock or relock the detector.
module request_stride_lock_detector_core #(
   parameter int LOCK_LENGTH = 3
) (
   input  logic       clock,
   input  logic       reset,
   rsld_req_if.sink   req,
   rsld_rsp_if.source rsp
);

   logic                 in_valid_ff;
   rsld_pkg::index_type  in_index_ff;
   logic                 out_valid_ff;
   rsld_pkg::result_type out_ff;
   rsld_pkg::result_type result;
   logic                 advance;

   // advance the held request when the result register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   rsld_tracker #(.LOCK_LENGTH(LOCK_LENGTH)) u_tracker (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .frame_index (in_index_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req.ready) begin
            in_valid_ff <= req.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_index_ff <= req.frame_index;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp.valid             = out_valid_ff;
   assign rsp.is_locked_out     = out_ff.is_locked_out;
   assign rsp.locked_stride_out = out_ff.locked_stride_out;
   assign rsp.prefetch_step     = out_ff.prefetch_step;

   a_step_locked: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.is_locked_out |->
         out_ff.prefetch_step == out_ff.locked_stride_out)
      else $error("locked step differs from locked stride");

   a_step_unlocked: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.is_locked_out |->
         out_ff.prefetch_step == rsld_pkg::stride_type'(1))
      else $error("unlocked step is not one");

   a_hold_request: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_index_ff))
      else $error("held request lost while result side stalled");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced request produced no result");

endmodule

>>> tb/sv/stride_lock_checker.sv
// Checker for the stride lock detector: tracks the stride state and compares every result.
module stride_lock_checker #(
   parameter int LOCK_LENGTH = 3
) (
   input  logic clock,
   input  logic reset,
   rsld_req_if  req,
   rsld_rsp_if  rsp,
   output int   mismatches,
   output int   awaiting,
   output int   results_checked,
   output int   locked_results
);

   localparam logic [2:0] LOCK_MAX = 3'(LOCK_LENGTH);

   // detector state as the block should hold it
   rsld_pkg::index_type  last_idx;
   rsld_pkg::stride_type lock_stride;
   rsld_pkg::stride_type cand_stride;
   logic [2:0]           hits;
   logic [2:0]           misses;
   logic                 locked;

   rsld_pkg::result_type expected_results[$];

   function automatic logic [2:0] bump(input logic [2:0] count);
      return (count >= LOCK_MAX) ? LOCK_MAX : count + 3'd1;
   endfunction

   function automatic rsld_pkg::result_type track_request(input rsld_pkg::index_type idx);
      rsld_pkg::stride_type step;
      rsld_pkg::result_type r;
      step = rsld_pkg::stride_type'({1'b0, idx}) - rsld_pkg::stride_type'({1'b0, last_idx});
      last_idx = idx;
      if (step == '0) step = rsld_pkg::stride_type'(1);

      if (locked) begin
         if (lock_stride == step) begin
            hits = '0;
            misses = '0;
         end else if (cand_stride == step) begin
            hits = bump(hits);
            misses = bump(misses);
         end else begin
            hits = '0;
            misses = bump(misses);
         end
         cand_stride = step;
         if (misses >= LOCK_MAX && hits >= LOCK_MAX) begin
            // relock onto the new stride
            lock_stride = cand_stride;
            hits = '0;
            misses = '0;
         end else if (misses >= LOCK_MAX) begin
            locked = 1'b0;
         end
      end else begin
         // candidate stays frozen while unlocked
         if (cand_stride == step) begin
            hits = bump(hits);
            misses = '0;
         end else begin
            hits = '0;
            misses = bump(misses);
         end
         if (hits >= LOCK_MAX) begin
            lock_stride = step;
            misses = '0;
            locked = 1'b1;
         end
      end

      r.is_locked_out = locked;
      r.locked_stride_out = lock_stride;
      r.prefetch_step = locked ? lock_stride : rsld_pkg::stride_type'(1);
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, name,
                  $signed(want), $signed(got));
      end
   endtask

   always @(posedge clock) begin
      rsld_pkg::result_type want;
      if (reset) begin
         last_idx = '0;
         lock_stride = rsld_pkg::stride_type'(1);
         cand_stride = rsld_pkg::stride_type'(1);
         hits = '0;
         misses = '0;
         locked = 1'b0;
         expected_results.delete();
         awaiting <= 0;
      end else begin
         // retire before queueing: a result never belongs to the same-edge request
         if (rsp.valid && rsp.ready) begin
            if (expected_results.size() == 0) begin
               mismatches++;
               $display("%0t: result with no request pending: expected none, got %0b %0d %0d",
                        $time, rsp.is_locked_out, rsp.locked_stride_out, rsp.prefetch_step);
            end else begin
               want = expected_results.pop_front();
               check_field("is_locked_out", 32'(want.is_locked_out), 32'(rsp.is_locked_out));
               check_field("locked_stride_out", want.locked_stride_out, rsp.locked_stride_out);
               check_field("prefetch_step", want.prefetch_step, rsp.prefetch_step);
               results_checked++;
               if (rsp.is_locked_out) locked_results++;
            end
         end
         if (req.valid && req.ready) expected_results.push_back(track_request(req.frame_index));
         awaiting <= expected_results.size();
      end
   end

endmodule

>>> tb/sv/testbench.sv
// Top of the stride lock detector bench: clock, reset, request stimulus and verdict.
module testbench;

   localparam int     LOCK_LENGTH = 3;
   localparam longint INDEX_MAX   = 64'h7FFF_FFFF;

   logic clock;
   logic reset;

   int send_idle_pct;
   int rsp_stall_pct;
   int mismatches;
   int awaiting;
   int results_checked;
   int locked_results;
   int requests_sent;

   rsld_pkg::index_type cur_index;
   int                  stride_mags [8];
   int                  idle_plan   [4] = '{0, 73, 0, 24};
   int                  stall_plan  [4] = '{0, 0, 73, 24};

   // lock on 1, miss out, lock on 5, relock-free unlock onto -7, lock on -7, edges
   rsld_pkg::index_type directed_frames [25] = '{
      31'd0, 31'd1, 31'd2, 31'd2, 31'h7FFF_FFFF, 31'd0, 31'd1, 31'd6, 31'd11,
      31'd16, 31'd21, 31'd26, 31'd100, 31'd100, 31'd93, 31'd86, 31'd79, 31'd80,
      31'd73, 31'd66, 31'd59, 31'd52, 31'h7FFF_FFFF, 31'h7FFF_FFF8, 31'h7FFF_FFF1
   };

   rsld_req_if req_bus ();
   rsld_rsp_if rsp_bus ();

   request_stride_lock_detector_core #(
      .LOCK_LENGTH(LOCK_LENGTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req  (req_bus),
      .rsp  (rsp_bus)
   );

   stride_lock_checker #(
      .LOCK_LENGTH(LOCK_LENGTH)
   ) lock_check (
      .clock          (clock),
      .reset          (reset),
      .req            (req_bus),
      .rsp            (rsp_bus),
      .mismatches     (mismatches),
      .awaiting       (awaiting),
      .results_checked(results_checked),
      .locked_results (locked_results)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic send_frame(input rsld_pkg::index_type idx);
      // idle cycles carry junk on the index lines
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         req_bus.frame_index <= rsld_pkg::index_type'($urandom);
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.frame_index <= idx;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      requests_sent++;
   endtask

   task automatic send_run(input int step, input int count);
      for (int k = 0; k < count; k++) begin
         cur_index = rsld_pkg::index_type'(longint'(cur_index) + step);
         send_frame(cur_index);
      end
   endtask

   // mostly runs of a repeated stride drawn from a small pool, some short jumps
   task automatic random_traffic(input int items);
      int     sent;
      int     pick;
      int     mag;
      int     len;
      int     step;
      longint room_up;
      longint room_down;
      longint span;
      sent = 0;
      while (sent < items) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            // jump, and remember its size so a later run can lock onto it
            mag = $urandom_range(1, 1 << 26);
            stride_mags[$urandom_range(1, 7)] = mag;
            len = 1;
         end else begin
            mag = (pick < 20) ? 0 : stride_mags[$urandom_range(7)];
            len = $urandom_range(1, 8);
         end
         if ($urandom_range(99) < 4) begin
            stride_mags[$urandom_range(1, 7)] = ($urandom_range(3) == 0) ?
               $urandom_range(1, 1 << 28) : $urandom_range(1, 32);
         end
         step = $urandom_range(1) ? mag : -mag;
         if (mag != 0) begin
            room_up = INDEX_MAX - longint'(cur_index);
            room_down = longint'(cur_index);
            span = longint'(mag) * len;
            if (span > room_up && span > room_down) begin
               step = (room_up > room_down) ? mag : -mag;
               len = int'(((room_up > room_down) ? room_up : room_down) / mag);
            end else if (step > 0 && span > room_up) begin
               step = -mag;
            end else if (step < 0 && span > room_down) begin
               step = mag;
            end
         end
         send_run(step, len);
         sent += len;
      end
   endtask

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.frame_index <= '0;
      reset <= 1'b1;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      requests_sent = 0;
      stride_mags = '{1, 2, 3, 5, 8, 64, 4096, 1 << 27};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_frames[i]) send_frame(directed_frames[i]);
      cur_index = directed_frames[24];

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = idle_plan[p];
         rsp_stall_pct = stall_plan[p];
         random_traffic(308);
         // hold off until every outstanding transaction has drained
         req_bus.valid <= 1'b0;
         do @(posedge clock); while (awaiting != 0);
      end

      repeat (8) @(posedge clock);
      $display("summary: %0d frame requests over four idle/stall mixes, %0d results checked",
               requests_sent, results_checked);
      $display("summary: %0d results reported a locked stride", locked_results);
      if (mismatches == 0 && awaiting == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("timeout with %0d results outstanding", awaiting);
      $display("testbench: done, errors");
      $finish;
   end

endmodule
